FILE: hw/rtl/scpp_pkg.sv
// Shared types and constants for the sync/length/checksum packet row parser.
// Used by scpp_row_dec and sync_checksum_packet_row_parser; no dependencies.
package scpp_pkg;

    localparam logic [7:0] SYNC_BYTE   = 8'hAA;
    localparam logic [7:0] EXTEND_BYTE = 8'h55;
    localparam logic [7:0] RAW_CODE    = 8'h80;
    localparam logic [7:0] BAND_CODE   = 8'h83;
    localparam logic [7:0] EVENT_FIRST = 8'hD0;
    localparam logic [7:0] EVENT_LAST  = 8'hD4;

    typedef enum logic [2:0] {
        KIND_SINGLE    = 3'd0,
        KIND_RAW       = 3'd1,
        KIND_BAND      = 3'd2,
        KIND_EVENT     = 3'd3,
        KIND_LONG      = 3'd4,
        KIND_GOOD      = 3'd5,
        KIND_BAD       = 3'd6,
        KIND_MALFORMED = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        RP_CODE = 3'b001,
        RP_LEN  = 3'b010,
        RP_DATA = 3'b100
    } t_row_phase;

    typedef struct packed {
        t_row_phase  phase;
        logic [7:0]  code;
        logic [7:0]  row_len;
        logic [7:0]  seen;
        logic [23:0] acc;
        logic [7:0]  ext;
    } t_row_state;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         row_code;
        logic [7:0]         extend_count;
        logic signed [24:0] value;
        logic [2:0]         band_index;
        logic [7:0]         row_length;
        logic [7:0]         payload_size;
        logic [7:0]         sum_received;
        logic [7:0]         sum_computed;
    } t_result;

    // Return to code hunting; code and declared length are kept.
    function automatic t_row_state clear_row(input t_row_state r);
        t_row_state c;
        c       = r;
        c.phase = RP_CODE;
        c.ext   = 8'd0;
        c.seen  = 8'd0;
        c.acc   = 24'd0;
        return c;
    endfunction

endpackage

FILE: hw/rtl/sync_checksum_packet_row_parser.sv
// Sync/length/checksum packet parser with coded row decoding, top level.
// Depends on scpp_pkg and scpp_row_dec.
//
// One received byte per cycle while the output word is not held. A byte is
// taken into the input register at the accepting edge. It is decoded against
// the frame and row state while it is held there, and its result, if it has
// one, is loaded into the output register as the byte moves on. The frame and
// row state update once per byte. A held output word stalls the input
// register, and tready drops only while both registers are full. The block
// hunts for two 0xAA bytes and a length below 0xAA. It emits row results
// (single values, raw samples, band powers, headset events, other long rows)
// as they complete, and ends each packet with a verdict: good, bad checksum,
// or malformed when a row overran the payload. Rows of a packet whose verdict
// is not good must be discarded.
module sync_checksum_packet_row_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] row_code, [15:8] extend_count, [40:16] value, [43:41] band_index,
    // [51:44] row_length, [59:52] payload_size, [67:60] sum_received,
    // [75:68] sum_computed, [79:76] zero
    output logic [79:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser    // [2:0] kind
);
    import scpp_pkg::*;

    typedef enum logic [4:0] {
        PH_SYNC1   = 5'b00001,
        PH_SYNC2   = 5'b00010,
        PH_LEN     = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_CSUM    = 5'b10000
    } t_frame_phase;

    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         r_out_valid;
    t_result      r_out;

    t_frame_phase r_phase, n_phase;
    logic [7:0]   r_plen, n_plen;
    logic [7:0]   r_prem, n_prem;
    logic [7:0]   r_sum, n_sum;
    logic         r_overrun, n_overrun;
    t_row_state   r_row, n_row;

    t_result      n_res;
    logic         n_res_valid;

    t_row_state   w_dec_row;
    t_result      w_dec_res;
    logic         w_dec_valid;
    logic         w_adv;
    logic         w_fire;
    logic [7:0]   w_calc;

    scpp_row_dec u_row_dec (
        .i_row       (r_row),
        .i_byte      (r_in_byte),
        .o_row       (w_dec_row),
        .o_res_valid (w_dec_valid),
        .o_res       (w_dec_res)
    );

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_calc        = ~r_sum;

    always_comb begin
        n_phase     = r_phase;
        n_plen      = r_plen;
        n_prem      = r_prem;
        n_sum       = r_sum;
        n_overrun   = r_overrun;
        n_row       = r_row;
        n_res       = '0;
        n_res_valid = 1'b0;
        unique case (r_phase)
            PH_SYNC1: begin
                if (r_in_byte == SYNC_BYTE) begin
                    n_phase = PH_SYNC2;
                end
            end
            PH_SYNC2: begin
                n_phase = (r_in_byte == SYNC_BYTE) ? PH_LEN : PH_SYNC1;
            end
            PH_LEN: begin
                priority if (r_in_byte == SYNC_BYTE) begin
                    n_phase = PH_LEN;
                end else if (r_in_byte > SYNC_BYTE) begin
                    n_phase = PH_SYNC1;
                end else begin
                    n_plen        = r_in_byte;
                    n_prem        = r_in_byte;
                    n_sum         = 8'd0;
                    n_overrun     = 1'b0;
                    n_row         = clear_row(r_row);
                    n_row.code    = 8'd0;
                    n_row.row_len = 8'd0;
                    n_phase       = (r_in_byte == 8'd0) ? PH_CSUM : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_sum       = r_sum + r_in_byte;
                n_row       = w_dec_row;
                n_res       = w_dec_res;
                n_res_valid = w_dec_valid;
                n_prem      = r_prem - {7'd0, (r_prem != 8'd0)};
                if (n_prem == 8'd0) begin
                    // payload ends inside a row: drop the row, flag overrun
                    if (w_dec_row.phase != RP_CODE) begin
                        n_overrun = 1'b1;
                    end
                    n_row   = clear_row(w_dec_row);
                    n_phase = PH_CSUM;
                end
            end
            PH_CSUM: begin
                n_res_valid        = 1'b1;
                n_res.payload_size = r_plen;
                n_res.sum_received = r_in_byte;
                n_res.sum_computed = w_calc;
                priority if (w_calc != r_in_byte) begin
                    n_res.kind = KIND_BAD;
                end else if (r_overrun) begin
                    n_res.kind = KIND_MALFORMED;
                end else begin
                    n_res.kind = KIND_GOOD;
                end
                n_overrun = 1'b0;
                n_row     = clear_row(r_row);
                n_phase   = PH_SYNC1;
            end
            default: begin
                n_phase = PH_SYNC1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SYNC1;
            r_plen    <= 8'd0;
            r_prem    <= 8'd0;
            r_sum     <= 8'd0;
            r_overrun <= 1'b0;
            r_row     <= '{phase: RP_CODE, default: '0};
        end else if (w_fire) begin
            r_phase   <= n_phase;
            r_plen    <= n_plen;
            r_prem    <= n_prem;
            r_sum     <= n_sum;
            r_overrun <= n_overrun;
            r_row     <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_fire && n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {4'd0, r_out.sum_computed, r_out.sum_received, r_out.payload_size,
                            r_out.row_length, r_out.band_index, r_out.value,
                            r_out.extend_count, r_out.row_code};

    // input register only stalls when it holds a word that cannot move on
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && !w_adv))
        else $error("input stalled with free register");

    // a checksum byte always yields a verdict in the next cycle
    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_phase == PH_CSUM) |=>
        (r_out_valid && (r_out.kind == KIND_GOOD || r_out.kind == KIND_BAD ||
                         r_out.kind == KIND_MALFORMED)))
        else $error("checksum byte gave no verdict");

    a_rehunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_phase == PH_CSUM) |=> (r_phase == PH_SYNC1))
        else $error("hunt not restarted after checksum");

    // row results never carry packet-level fields
    a_row_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind != KIND_GOOD && r_out.kind != KIND_BAD &&
         r_out.kind != KIND_MALFORMED) |->
        (r_out.payload_size == 8'd0 && r_out.sum_received == 8'd0 &&
         r_out.sum_computed == 8'd0))
        else $error("row result carries verdict fields");

    a_raw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_RAW) |->
        (r_out.value[24:15] == 10'd0 || r_out.value[24:15] == 10'h3FF))
        else $error("raw sample not a sign-extended 16-bit value");

endmodule

FILE: hw/rtl/scpp_row_dec.sv
// Row decoder: one payload byte against the current row state.
// Gives the next row state and at most one row result. Depends on scpp_pkg.
module scpp_row_dec (
    input  scpp_pkg::t_row_state i_row,
    input  logic [7:0]           i_byte,
    output scpp_pkg::t_row_state o_row,
    output logic                 o_res_valid,
    output scpp_pkg::t_result    o_res
);
    import scpp_pkg::*;

    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_close;

    // Closing result of a long row that produced nothing on the way.
    function automatic t_close close_kind(input logic [7:0] code, input logic [7:0] rlen);
        t_close c;
        c.valid = 1'b1;
        c.kind  = KIND_LONG;
        if (code >= EVENT_FIRST && code <= EVENT_LAST) begin
            c.kind = KIND_EVENT;
        end else if (code == RAW_CODE) begin
            c.valid = (rlen < 8'd2);
        end else if (code == BAND_CODE) begin
            c.valid = (rlen < 8'd3);
        end
        return c;
    endfunction

    logic [23:0] w_acc;
    logic [7:0]  w_seen;
    logic        w_band_hit;
    logic [2:0]  w_band;
    logic        w_emit;
    t_close      w_close;

    assign w_acc  = {i_row.acc[15:0], i_byte};
    assign w_seen = i_row.seen + 8'd1;

    always_comb begin
        w_band_hit = 1'b1;
        w_band     = 3'd0;
        unique case (w_seen)
            8'd3:    w_band = 3'd0;
            8'd6:    w_band = 3'd1;
            8'd9:    w_band = 3'd2;
            8'd12:   w_band = 3'd3;
            8'd15:   w_band = 3'd4;
            8'd18:   w_band = 3'd5;
            8'd21:   w_band = 3'd6;
            8'd24:   w_band = 3'd7;
            default: w_band_hit = 1'b0;
        endcase
    end

    always_comb begin
        o_row       = i_row;
        o_res_valid = 1'b0;
        o_res       = '0;
        w_emit      = 1'b0;
        w_close     = '0;
        o_res.row_code     = i_row.code;
        o_res.extend_count = i_row.ext;
        unique case (i_row.phase)
            RP_CODE: begin
                if (i_byte == EXTEND_BYTE) begin
                    if (i_row.ext != 8'hFF) begin
                        o_row.ext = i_row.ext + 8'd1;
                    end
                end else begin
                    o_row.code = i_byte;
                    o_row.acc  = 24'd0;
                    o_row.seen = 8'd0;
                    if (i_byte[7]) begin
                        o_row.phase = RP_LEN;
                    end else begin
                        o_row.row_len = 8'd1;
                        o_row.phase   = RP_DATA;
                    end
                end
            end
            RP_LEN: begin
                o_row.row_len = i_byte;
                o_row.seen    = 8'd0;
                o_row.acc     = 24'd0;
                o_row.phase   = RP_DATA;
                if (i_byte == 8'd0) begin
                    // empty long row closes at once with a zero value
                    w_close          = close_kind(i_row.code, 8'd0);
                    o_res_valid      = w_close.valid;
                    o_res.kind       = w_close.kind;
                    o_res.row_length = 8'd0;
                    o_row            = clear_row(o_row);
                end
            end
            RP_DATA: begin
                o_row.acc  = w_acc;
                o_row.seen = w_seen;
                if (!i_row.code[7]) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_SINGLE;
                    o_res.value = {17'd0, i_byte};
                    o_row       = clear_row(o_row);
                end else begin
                    o_res.row_length = i_row.row_len;
                    if (i_row.code == RAW_CODE && w_seen == 8'd2) begin
                        w_emit      = 1'b1;
                        o_res.kind  = KIND_RAW;
                        o_res.value = {{9{w_acc[15]}}, w_acc[15:0]};
                    end else if (i_row.code == BAND_CODE && w_band_hit) begin
                        w_emit           = 1'b1;
                        o_res.kind       = KIND_BAND;
                        o_res.value      = {1'b0, w_acc};
                        o_res.band_index = w_band;
                    end
                    o_res_valid = w_emit;
                    if (w_seen >= i_row.row_len) begin
                        if (!w_emit) begin
                            w_close     = close_kind(i_row.code, i_row.row_len);
                            o_res_valid = w_close.valid;
                            o_res.kind  = w_close.kind;
                            o_res.value = {17'd0, w_acc[7:0]};
                        end
                        o_row = clear_row(o_row);
                    end
                end
            end
            default: begin
                o_row = clear_row(i_row);
            end
        endcase
    end

endmodule
